// ===== rtl/core/mte_pkg.sv =====
`default_nettype none

package mte_pkg;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] key_row;
        logic [2:0] key_col;
    } in_beat_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic       preview_valid;
        logic [7:0] preview_code;
    } out_beat_t;

    localparam int unsigned NUM_KEYS = 12;
    localparam int unsigned MAX_TAPS = 5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd800;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    // Character sets by key index, unused slots are zero.
    localparam logic [7:0] CHARSET [NUM_KEYS][MAX_TAPS] = '{
        '{8'h5F, 8'h2C, 8'h40, 8'h31, 8'h00},  // _ , @ 1
        '{8'h41, 8'h42, 8'h43, 8'h32, 8'h00},  // A B C 2
        '{8'h44, 8'h45, 8'h46, 8'h33, 8'h00},  // D E F 3
        '{8'h47, 8'h48, 8'h49, 8'h34, 8'h00},  // G H I 4
        '{8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h00},  // J K L 5
        '{8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h00},  // M N O 6
        '{8'h50, 8'h51, 8'h52, 8'h53, 8'h37},  // P Q R S 7
        '{8'h54, 8'h55, 8'h56, 8'h38, 8'h00},  // T U V 8
        '{8'h57, 8'h58, 8'h59, 8'h5A, 8'h39},  // W X Y Z 9
        '{8'h5F, 8'h28, 8'h29, 8'h00, 8'h00},  // _ ( )
        '{8'h30, 8'h20, 8'h00, 8'h00, 8'h00},  // 0 space
        '{8'h23, 8'h0A, 8'h00, 8'h00, 8'h00}   // # newline
    };

    localparam logic [2:0] CHARSET_LEN [NUM_KEYS] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd2, 3'd2
    };

    function automatic logic [2:0] key_len(input logic [3:0] key);
        logic [2:0] len;
        if (key < 4'(NUM_KEYS)) begin
            len = CHARSET_LEN[key];
        end else begin
            len = CHARSET_LEN[0];
        end
        return len;
    endfunction

    // Keys above eleven fall back to key zero. A tap of five or more gives code zero.
    function automatic logic [7:0] key_char(input logic [3:0] key, input logic [2:0] tap);
        logic [3:0] k;
        logic [7:0] code;
        k = (key < 4'(NUM_KEYS)) ? key : 4'd0;
        if (tap < 3'(MAX_TAPS)) begin
            code = CHARSET[k][tap];
        end else begin
            code = 8'h00;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/multitap_text_entry.sv =====
`default_nettype none

// Multi-tap keypad text entry. Each input beat is a millisecond tick, a key
// release on the 4x3 matrix or a clear, and each one produces exactly one
// result beat with the confirmed character (if any) and the pending preview.
// The block takes one beat per clock: the key state is updated and the result
// is computed in the same cycle, and the result sits in a single output
// register that may be refilled in the cycle it is taken, so s_ready only
// drops while that register is held by m_ready low. timeout_reg is written
// through cfg_wr_en/cfg_wr_data and resets to 800.
module multitap_text_entry
    import mte_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    logic [15:0] timeout_reg;
    logic        pend_valid_reg, pend_valid_next;
    logic [3:0]  pend_key_reg, pend_key_next;
    logic [2:0]  tap_reg, tap_next;
    logic [15:0] idle_reg, idle_next;
    logic        m_valid_reg;
    out_beat_t   m_data_reg, m_data_next;

    logic        accept;
    logic [15:0] idle_inc;
    logic [3:0]  key;
    logic [2:0]  len;
    logic        col_ok;
    logic        confirm;
    logic [7:0]  confirm_code;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign key      = 4'({s_data.key_row, 1'b0}) + 4'(s_data.key_row)
                      + 4'(s_data.key_col) - 4'd1;
    assign len      = key_len(key);
    assign col_ok   = (s_data.key_col >= 3'd1) && (s_data.key_col <= 3'd3);
    assign confirm_code = key_char(pend_key_reg, tap_reg);

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        tap_next        = tap_reg;
        idle_next       = idle_reg;
        confirm         = 1'b0;
        unique case (mode_t'(s_data.mode))
            MODE_TICK: begin
                idle_next = idle_inc;
                if (pend_valid_reg && (idle_inc > timeout_reg)) begin
                    confirm         = 1'b1;
                    pend_valid_next = 1'b0;
                    pend_key_next   = 4'd0;
                    tap_next        = 3'd0;
                    idle_next       = 16'd0;
                end
            end
            MODE_RELEASE: begin
                if (col_ok) begin
                    idle_next = 16'd0;
                    if (pend_valid_reg && (pend_key_reg == key)) begin
                        tap_next = (tap_reg + 3'd1 >= len) ? 3'd0 : tap_reg + 3'd1;
                    end else begin
                        confirm         = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_key_next   = key;
                        tap_next        = 3'd0;
                    end
                end
            end
            MODE_CLEAR: begin
                pend_valid_next = 1'b0;
                pend_key_next   = 4'd0;
                tap_next        = 3'd0;
                idle_next       = 16'd0;
            end
            MODE_NONE: begin
            end
            default: begin
            end
        endcase

        m_data_next.char_valid    = confirm;
        m_data_next.char_code     = confirm ? confirm_code : 8'h00;
        m_data_next.preview_valid = pend_valid_next;
        m_data_next.preview_code  = pend_valid_next ? key_char(pend_key_next, tap_next)
                                                    : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            pend_valid_reg <= 1'b0;
            pend_key_reg   <= 4'd0;
            tap_reg        <= 3'd0;
            idle_reg       <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (accept) begin
                pend_valid_reg <= pend_valid_next;
                pend_key_reg   <= pend_key_next;
                tap_reg        <= tap_next;
                idle_reg       <= idle_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mte_checker.sv =====
`default_nettype none

module mte_checker
    import mte_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire in_beat_t    s_data,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire out_beat_t   m_data
);

    // A stalled result beat holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.char_valid |-> m_data.char_code == 8'h00)
        else $error("char_code not zero without a confirmed character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.preview_valid |-> m_data.preview_code == 8'h00)
        else $error("preview_code not zero without a pending character");

    // A clear beat drops the pending character without confirming it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_CLEAR
        |=> m_valid && !m_data.char_valid && !m_data.preview_valid)
        else $error("clear beat produced a character");

endmodule

bind multitap_text_entry mte_checker u_mte_checker (.*);

`default_nettype wire
